// File: rtl/core/lcts_pkg.sv
// ----------------------------------------------------------------------------
// lcts_pkg
// shared sizes, action and status codes, and the controller/datapath bundles
// for the lod chain table select core
// ----------------------------------------------------------------------------
package lcts_pkg;

  localparam int CHAIN_SLOTS = 16;
  localparam int LEVELS      = 4;

  localparam int SLOT_W    = (CHAIN_SLOTS > 1) ? $clog2(CHAIN_SLOTS) : 1;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W     = $clog2(LEVELS + 1);
  localparam int USED_W    = $clog2(CHAIN_SLOTS + 1);
  localparam int MEM_DEPTH = CHAIN_SLOTS * LEVELS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_SELECT     = 3'd0;
  localparam action_t ACT_SELECT_SQ  = 3'd1;
  localparam action_t ACT_LEVEL_AT   = 3'd2;
  localparam action_t ACT_REGISTER   = 3'd3;
  localparam action_t ACT_UNREGISTER = 3'd4;
  localparam action_t ACT_CLEAR      = 3'd5;
  localparam action_t ACT_QUERY      = 3'd6;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_STAGED  = 2'd1;
  localparam status_t ST_INVALID = 2'd2;
  localparam status_t ST_NO_SLOT = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the transaction
    logic prep;      // square the distance, compare keys
    logic look;      // encode hit slot and free slot
    logic sel_init;  // chain found: start the rung walk
    logic nokey;     // no chain: echo the key
    logic rung_rd;   // read one rung
    logic rung_cmp;  // compare the rung just read
    logic stage;     // stage one registration level
    logic commit;    // commit the staged chain
    logic copy;      // copy one staged rung into the table
    logic unreg;
    logic clr;
    logic query;
    logic invalid;
  } lcts_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t action;
    logic    hit;
    logic    free_any;
    logic    last;
    logic    level_zero;
    logic    rung_hit;
    logic    rung_last;
    logic    commit_ok;
    logic    copy_last;
  } lcts_stat_t;

endpackage

// File: rtl/core/lod_chain_table_select_core.sv
// ----------------------------------------------------------------------------
// lod_chain_table_select_core
// distance based level-of-detail selection over a table of lod chains
// ----------------------------------------------------------------------------
// one transaction at a time: start is taken when busy is low, and exactly one
// result follows, shown for a single cycle with out_valid. the receiver cannot
// stall, so sample the out_ ports whenever out_valid is high. after the
// accepting edge a transaction passes prep, look and exec and ends with the
// strobe in done. query, unregister, clear, a non-final register level, an
// unknown action and a select with no chain go from exec straight to done; a
// select on a chain walks its rungs, one rung memory read and one 64-bit
// compare each, up to LEVELS rungs; the final register level adds a commit
// state, then copies each staged rung into the rung memory. busy stays high
// through the strobe cycle, so the next start is taken the cycle after it. the
// rung memory has a single access port, which sets the walk and copy lengths.
// ----------------------------------------------------------------------------
module lod_chain_table_select_core import lcts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_key,
  input  logic [31:0] in_level_handle,
  input  logic [31:0] in_level_max_distance,
  input  logic        in_last_level,
  input  logic [31:0] in_distance,
  input  logic [63:0] in_distance_squared,
  // result channel
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_handle_out,
  output logic [4:0]  out_level_out,
  output logic        out_culled,
  output logic        out_chain_found,
  output logic [4:0]  out_chains_in_use
);

  // sequencer drives the datapath through one command bundle and watches
  // one status bundle
  lcts_cmd_t  cmd;
  lcts_stat_t st;

  lcts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  // slot table, rung memory, staging buffer and squarer
  lcts_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .in_action             (in_action),
    .in_key                (in_key),
    .in_level_handle       (in_level_handle),
    .in_level_max_distance (in_level_max_distance),
    .in_last_level         (in_last_level),
    .in_distance           (in_distance),
    .in_distance_squared   (in_distance_squared),
    .out_status            (out_status),
    .out_handle_out        (out_handle_out),
    .out_level_out         (out_level_out),
    .out_culled            (out_culled),
    .out_chain_found       (out_chain_found),
    .out_chains_in_use     (out_chains_in_use)
  );

endmodule

// File: rtl/core/lcts_ctrl.sv
// ----------------------------------------------------------------------------
// lcts_ctrl
// sequencer for the lod chain table select core: one transaction at a time
// ----------------------------------------------------------------------------
module lcts_ctrl import lcts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  input  lcts_stat_t st,
  output lcts_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_LOOK   = 4'd2;
  localparam logic [3:0] S_EXEC   = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_COMMIT = 4'd6;
  localparam logic [3:0] S_COPY   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (st.action)
          ACT_SELECT, ACT_SELECT_SQ, ACT_LEVEL_AT: begin
            if (!st.hit) begin
              cmd.nokey = 1'b1;
            end else begin
              cmd.sel_init = 1'b1;
              if (!st.level_zero) state_nxt = S_RD;
            end
          end
          ACT_REGISTER: begin
            cmd.stage = 1'b1;
            if (st.last) state_nxt = S_COMMIT;
          end
          ACT_UNREGISTER: cmd.unreg   = 1'b1;
          ACT_CLEAR:      cmd.clr     = 1'b1;
          ACT_QUERY:      cmd.query   = 1'b1;
          default:        cmd.invalid = 1'b1;
        endcase
      end
      S_RD: begin
        cmd.rung_rd = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.rung_cmp = 1'b1;
        state_nxt    = (st.rung_hit || st.rung_last) ? S_DONE : S_RD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = (st.commit_ok && (st.hit || st.free_any)) ? S_COPY : S_DONE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (st.copy_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_copy_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy |-> $past(cmd.commit) || $past(cmd.copy))
    else $error("rung copy without a commit");
`endif

endmodule

// File: rtl/core/lcts_dpath.sv
// ----------------------------------------------------------------------------
// lcts_dpath
// chain slot table, rung memory, staging buffer, squarer and result registers
// ----------------------------------------------------------------------------
module lcts_dpath import lcts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lcts_cmd_t   cmd,
  output lcts_stat_t  st,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_key,
  input  logic [31:0] in_level_handle,
  input  logic [31:0] in_level_max_distance,
  input  logic        in_last_level,
  input  logic [31:0] in_distance,
  input  logic [63:0] in_distance_squared,
  output logic [1:0]  out_status,
  output logic [31:0] out_handle_out,
  output logic [4:0]  out_level_out,
  output logic        out_culled,
  output logic        out_chain_found,
  output logic [4:0]  out_chains_in_use
);

  function automatic logic [ADDR_W-1:0] rung_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [LVL_W-1:0]  rung);
    return ADDR_W'(slot) * ADDR_W'(LEVELS) + ADDR_W'(rung);
  endfunction

  // captured transaction
  action_t     act_r;
  logic [31:0] key_r;
  logic [31:0] lh_r;
  logic [31:0] lim_r;
  logic        last_r;
  logic [31:0] dist_r;
  logic [63:0] dsq_r;

  logic [63:0]            prod_r;
  logic [CHAIN_SLOTS-1:0] match_r;
  logic                   hit_r;
  logic [SLOT_W-1:0]      hit_slot_r;
  logic                   free_any_r;
  logic [SLOT_W-1:0]      free_slot_r;
  logic [SLOT_W-1:0]      tgt_r;
  logic [LVL_W-1:0]       rung_r;
  logic [LVL_W-1:0]       copy_r;
  logic [31:0]            rd_h_r;
  logic [63:0]            rd_l_r;

  // chain slot table
  logic [CHAIN_SLOTS-1:0] slot_used_r;
  logic [31:0]            slot_key_r [CHAIN_SLOTS];
  logic [CNT_W-1:0]       slot_cnt_r [CHAIN_SLOTS];
  logic [USED_W-1:0]      used_count_r;

  // rung memory: handle over squared limit
  logic [95:0] rung_mem [MEM_DEPTH];

  // staging buffer
  logic [31:0]      stg_h_r [LEVELS];
  logic [63:0]      stg_l_r [LEVELS];
  logic [CNT_W-1:0] stg_cnt_r;
  logic             stg_err_r;
  logic [31:0]      stg_prev_r;

  // results
  status_t     status_r;
  logic [31:0] hout_r;
  logic [4:0]  lout_r;
  logic        culled_r;
  logic        found_r;

  logic [31:0]       mul_a;
  logic [63:0]       query;
  logic [CNT_W-1:0]  hit_cnt;
  logic              stage_ok;
  logic              stg_err_nxt;
  logic [LVL_W-1:0]  stg_idx;
  logic              commit_ok;
  logic [SLOT_W-1:0] tgt;
  logic              hit_any;
  logic [SLOT_W-1:0] hit_idx;
  logic              free_any;
  logic [SLOT_W-1:0] free_idx;

  assign mul_a       = (act_r == ACT_REGISTER) ? lim_r : dist_r;
  assign query       = (act_r == ACT_SELECT_SQ) ? dsq_r : prod_r;
  assign hit_cnt     = slot_cnt_r[hit_slot_r];
  assign stage_ok    = (lh_r != 32'd0) && (lim_r > stg_prev_r) &&
                       (stg_cnt_r < CNT_W'(LEVELS));
  assign stg_err_nxt = stg_err_r || !stage_ok;
  assign stg_idx     = stg_cnt_r[LVL_W-1:0];
  assign commit_ok   = !stg_err_r && (key_r != 32'd0) && (stg_cnt_r != '0);
  assign tgt         = hit_r ? hit_slot_r : free_slot_r;

  // lowest matching slot and lowest free slot
  always_comb begin
    hit_any  = |match_r;
    free_any = ~&slot_used_r;
    hit_idx  = '0;
    free_idx = '0;
    for (int s = CHAIN_SLOTS - 1; s >= 0; s--) begin
      if (match_r[s])      hit_idx  = SLOT_W'(s);
      if (!slot_used_r[s]) free_idx = SLOT_W'(s);
    end
  end

  always_comb begin
    st            = '0;
    st.action     = act_r;
    st.hit        = hit_r;
    st.free_any   = free_any_r;
    st.last       = last_r;
    st.level_zero = (hit_cnt == '0);
    st.rung_hit   = (query <= rd_l_r);
    st.rung_last  = ((CNT_W'(rung_r) + CNT_W'(1)) == hit_cnt);
    st.commit_ok  = commit_ok;
    st.copy_last  = ((CNT_W'(copy_r) + CNT_W'(1)) == stg_cnt_r);
  end

  // capture, squarer, lookup
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      key_r  <= in_key;
      lh_r   <= in_level_handle;
      lim_r  <= in_level_max_distance;
      last_r <= in_last_level;
      dist_r <= in_distance;
      dsq_r  <= in_distance_squared;
    end
    if (cmd.prep) begin
      prod_r <= 64'(mul_a) * 64'(mul_a);
      for (int s = 0; s < CHAIN_SLOTS; s++) begin
        match_r[s] <= slot_used_r[s] && (slot_key_r[s] == key_r) && (key_r != 32'd0);
      end
    end
    if (cmd.look) begin
      hit_r       <= hit_any;
      hit_slot_r  <= hit_idx;
      free_any_r  <= free_any;
      free_slot_r <= free_idx;
    end
    if (cmd.commit) begin
      tgt_r  <= tgt;
      copy_r <= '0;
    end
    if (cmd.copy) copy_r <= copy_r + LVL_W'(1);
    if (cmd.sel_init) rung_r <= '0;
    if (cmd.rung_cmp && !st.rung_hit) rung_r <= rung_r + LVL_W'(1);
  end

  // rung memory
  always_ff @(posedge clk) begin
    if (cmd.copy) begin
      rung_mem[rung_addr(tgt_r, copy_r)] <= {stg_h_r[copy_r], stg_l_r[copy_r]};
    end
    if (cmd.rung_rd) begin
      {rd_h_r, rd_l_r} <= rung_mem[rung_addr(hit_slot_r, rung_r)];
    end
  end

  // staging payload
  always_ff @(posedge clk) begin
    if (cmd.stage && stage_ok) begin
      stg_h_r[stg_idx] <= lh_r;
      stg_l_r[stg_idx] <= prod_r;
    end
  end

  // staging control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_cnt_r  <= '0;
      stg_err_r  <= 1'b0;
      stg_prev_r <= '0;
    end else if (cmd.stage) begin
      if (stage_ok) begin
        stg_cnt_r  <= stg_cnt_r + CNT_W'(1);
        stg_prev_r <= lim_r;
      end else begin
        stg_err_r  <= 1'b1;
      end
    end else if ((cmd.commit && !(commit_ok && (hit_r || free_any_r))) ||
                 (cmd.copy && st.copy_last)) begin
      stg_cnt_r  <= '0;
      stg_err_r  <= 1'b0;
      stg_prev_r <= '0;
    end
  end

  // slot table payload
  always_ff @(posedge clk) begin
    if (cmd.commit && commit_ok && (hit_r || free_any_r)) begin
      slot_key_r[tgt] <= key_r;
      slot_cnt_r[tgt] <= stg_cnt_r;
    end
  end

  // slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r  <= '0;
      used_count_r <= '0;
    end else if (cmd.clr) begin
      slot_used_r  <= '0;
      used_count_r <= '0;
    end else if (cmd.unreg && hit_r) begin
      slot_used_r[hit_slot_r] <= 1'b0;
      if (used_count_r != '0) used_count_r <= used_count_r - USED_W'(1);
    end else if (cmd.commit && commit_ok && (hit_r || free_any_r)) begin
      slot_used_r[tgt] <= 1'b1;
      if (!hit_r) used_count_r <= used_count_r + USED_W'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= ST_OK;
      hout_r   <= '0;
      lout_r   <= '0;
      culled_r <= 1'b0;
      found_r  <= 1'b0;
    end
    if (cmd.nokey) hout_r <= key_r;
    if (cmd.sel_init) begin
      found_r  <= 1'b1;
      lout_r   <= 5'(LEVELS);
      culled_r <= 1'b1;
    end
    if (cmd.rung_cmp && st.rung_hit) begin
      hout_r   <= rd_h_r;
      lout_r   <= 5'(rung_r);
      culled_r <= 1'b0;
    end
    if (cmd.stage) status_r <= stg_err_nxt ? ST_INVALID : ST_STAGED;
    if (cmd.commit) begin
      if (!commit_ok)                status_r <= ST_INVALID;
      else if (!hit_r && !free_any_r) status_r <= ST_NO_SLOT;
      else                           status_r <= ST_OK;
    end
    if (cmd.unreg || cmd.query) found_r <= hit_r;
    if (cmd.invalid) status_r <= ST_INVALID;
  end

  assign out_status        = status_r;
  assign out_handle_out    = hout_r;
  assign out_level_out     = lout_r;
  assign out_culled        = culled_r;
  assign out_chain_found   = found_r;
  assign out_chains_in_use = 5'(used_count_r);

`ifndef NO_ASSERTIONS
  a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_count_r) == $countones(slot_used_r))
    else $error("occupancy count out of step with slot valid bits");

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stg_cnt_r <= CNT_W'(LEVELS))
    else $error("staging buffer overfilled");

  a_copy_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy && st.copy_last |=> stg_cnt_r == '0 && !stg_err_r)
    else $error("staging not restarted after commit");
`endif

endmodule
